// File: rtl/core/bsim_pkg.sv
// box similarity error: shared widths, limits, reset values and register codes
// no dependencies; imported by the interfaces and the core
`timescale 1ns / 1ps

package bsim_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int COORD_BITS_DEF = 24;

  localparam int DIM_W     = 23;
  localparam int ASP_W     = 17;
  localparam int VOL_W     = 24;
  localparam int DIST_W    = 26;
  localparam int WGT_W     = 4;
  localparam int MIN_DIM_W = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [ASP_W-1:0]  ASP_MAX  = '1;
  localparam logic [VOL_W-1:0]  VOL_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [MIN_DIM_W-1:0] MIN_DIM_RST = 16'd3277;
  localparam logic [WGT_W-1:0]     W_ASP_RST   = 4'd3;
  localparam logic [WGT_W-1:0]     W_VOL_RST   = 4'd1;
  localparam logic [WGT_W-1:0]     W_DST_RST   = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIM    = 8'd0,
    REG_W_ASPECT   = 8'd1,
    REG_W_VOLUME   = 8'd2,
    REG_W_DISTANCE = 8'd3
  } cfg_reg_e;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: rtl/core/bsim_if.sv
// box similarity error: request, result and register write channels
// depends on bsim_pkg
`timescale 1ns / 1ps

interface bsim_in_if import bsim_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic        [DIM_W-1:0]      cand_dim_x;
  logic        [DIM_W-1:0]      cand_dim_y;
  logic        [DIM_W-1:0]      cand_dim_z;
  logic signed [COORD_BITS-1:0] cand_pos_x;
  logic signed [COORD_BITS-1:0] cand_pos_y;
  logic signed [COORD_BITS-1:0] cand_pos_z;
  logic        [DIM_W-1:0]      ref_dim_x;
  logic        [DIM_W-1:0]      ref_dim_y;
  logic        [DIM_W-1:0]      ref_dim_z;
  logic signed [COORD_BITS-1:0] ref_pos_x;
  logic signed [COORD_BITS-1:0] ref_pos_y;
  logic signed [COORD_BITS-1:0] ref_pos_z;

  modport source (
    output valid, cand_dim_x, cand_dim_y, cand_dim_z, cand_pos_x, cand_pos_y, cand_pos_z,
    output ref_dim_x, ref_dim_y, ref_dim_z, ref_pos_x, ref_pos_y, ref_pos_z,
    input  ready
  );
  modport sink (
    input  valid, cand_dim_x, cand_dim_y, cand_dim_z, cand_pos_x, cand_pos_y, cand_pos_z,
    input  ref_dim_x, ref_dim_y, ref_dim_z, ref_pos_x, ref_pos_y, ref_pos_z,
    output ready
  );
endinterface

interface bsim_out_if import bsim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ASP_W-1:0]  aspect_error;
  logic [VOL_W-1:0]  volume_error;
  logic [DIST_W-1:0] distance_error;
  logic [DIST_W-1:0] overall_error;
  logic [VOL_W-1:0]  static_error;

  modport source (
    output valid, aspect_error, volume_error, distance_error, overall_error, static_error,
    input  ready
  );
  modport sink (
    input  valid, aspect_error, volume_error, distance_error, overall_error, static_error,
    output ready
  );
endinterface

interface bsim_cfg_if import bsim_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/bsim_div.sv
// pipelined restoring divider, one quotient bit per register stage
// caller guarantees hi_i < div_i; a side word travels with each request
`timescale 1ns / 1ps

module bsim_div #(
  parameter int VW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] hi_i,
  input  logic [QW-1:0] lo_i,
  input  logic [VW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [VW-1:0] rem_q  [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [VW-1:0] div_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [VW-1:0] div_in;
    logic [SW-1:0] side_in;
    logic [VW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = hi_i;
      assign lo_in   = lo_i;
      assign div_in  = div_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign div_in  = div_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, lo_in[QW-1]};
    assign take  = trial >= {1'b0, div_in};

    // quotient bits shift in from the bottom as dividend bits leave the top
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? VW'(trial - {1'b0, div_in}) : trial[VW-1:0];
        lo_q[k]   <= {lo_in[QW-2:0], take};
        div_q[k]  <= div_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = lo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

// File: rtl/core/bsim_sqrt.sv
// pipelined integer square root, one root bit per register stage
// floor root of an IW-bit radicand; a side word travels with each request
`timescale 1ns / 1ps

module bsim_sqrt #(
  parameter int IW = 8,
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IW-1:0]    rad_i,
  input  logic [SW-1:0]    side_i,
  output logic [IW/2-1:0]  root_o,
  output logic [SW-1:0]    side_o
);

  localparam int OW = IW / 2;

  logic [OW+1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [IW-1:0] rad_q  [OW];
  logic [SW-1:0] side_q [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [OW+1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [IW-1:0] rad_in;
    logic [SW-1:0] side_in;
    logic [OW+3:0] t;
    logic [OW+3:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign t     = {rem_in, rad_in[IW-1 -: 2]};
    assign trial = (OW+4)'({root_in, 2'b01});
    assign take  = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (OW+2)'(t - trial) : t[OW+1:0];
        root_q[k] <= {root_in[OW-2:0], take};
        rad_q[k]  <= {rad_in[IW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[OW-1];
  assign side_o = side_q[OW-1];

endmodule

// File: rtl/core/box_similarity_error_core.sv
// box similarity error core: aspect, volume, distance and weighted errors
// one request accepted every cycle while no stalled result holds the pipeline
// the ratio divide and aspect root chain is the longest path, followed by the 32-stage mean divide
// a stalled result freezes the whole pipeline; nothing is dropped or repeated
// reset clears the valid pipeline and loads default register values; no clearing pass
// depends on bsim_pkg, bsim_if, bsim_div, bsim_sqrt
`timescale 1ns / 1ps

module box_similarity_error_core import bsim_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsim_cfg_if.sink    cfg_i,
  bsim_in_if.sink     in_i,
  bsim_out_if.source  out_o
);

  localparam int F        = FRAC_BITS;
  localparam int C        = COORD_BITS;
  localparam int RAT_W    = F + 1;
  localparam int ASQ_IW   = 2 * RAT_W + 2;
  localparam int ASQ_OW   = ASQ_IW / 2;
  localparam int VP_W     = 2 * DIM_W;
  localparam int VOL_P_W  = 3 * DIM_W;
  localparam int VD_W     = VOL_P_W + F;
  localparam int VSH_W    = VOL_W - F;
  localparam int DSQ_IW   = 2 * C + 2;
  localparam int DSQ_OW   = DSQ_IW / 2;
  localparam int MEAN_W   = DIST_W + WGT_W + 2;
  localparam int DEN_W    = WGT_W + 2;
  localparam int SB_W     = ASP_W + VOL_W + DIST_W;
  localparam int LAT_ASP  = RAT_W + 2 + ASQ_OW;
  localparam int LAT_VOL  = 4 + VOL_W;
  localparam int LAT_DST  = 2 + DSQ_OW;
  localparam int LAT_MAX  = max_int(max_int(LAT_ASP, LAT_VOL), LAT_DST);
  localparam int LAT_TOT  = 1 + LAT_MAX + 1 + MEAN_W + 1;
  localparam int DA_ASP   = LAT_MAX - LAT_ASP;
  localparam int DA_VOL   = LAT_MAX - LAT_VOL;
  localparam int DA_DST   = LAT_MAX - LAT_DST;

  function automatic logic [DIM_W-1:0] umax(input logic [DIM_W-1:0] a, input logic [DIM_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [DIM_W-1:0] umin(input logic [DIM_W-1:0] a, input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [C-1:0] pos_dist(input logic signed [C-1:0] a,
                                            input logic signed [C-1:0] b);
    logic signed [C:0] diff;
    diff = (C+1)'(a) - (C+1)'(b);
    return diff[C] ? C'(-diff) : C'(diff);
  endfunction

  // ---------------------------------------------------------------- config
  logic [MIN_DIM_W-1:0] min_dim_q;
  logic [WGT_W-1:0]     w_asp_q, w_vol_q, w_dst_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dim_q <= MIN_DIM_RST;
      w_asp_q   <= W_ASP_RST;
      w_vol_q   <= W_VOL_RST;
      w_dst_q   <= W_DST_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MIN_DIM:    min_dim_q <= cfg_i.data[MIN_DIM_W-1:0];
        REG_W_ASPECT:   w_asp_q   <= cfg_i.data[WGT_W-1:0];
        REG_W_VOLUME:   w_vol_q   <= cfg_i.data[WGT_W-1:0];
        REG_W_DISTANCE: w_dst_q   <= cfg_i.data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic [LAT_TOT-1:0] vld_q;
  logic               en;

  assign en         = !vld_q[LAT_TOT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT_TOT-2:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------- sort and floor
  logic [DIM_W-1:0] floor_v;
  logic [DIM_W-1:0] cs_d [3];
  logic [DIM_W-1:0] rs_d [3];
  logic [DIM_W-1:0] cs_q [3];
  logic [DIM_W-1:0] rs_q [3];
  logic [C-1:0]     d_q  [3];

  assign floor_v = (min_dim_q == '0) ? DIM_W'(1) : DIM_W'(min_dim_q);

  always_comb begin
    cs_d[0] = umax(umax(in_i.cand_dim_x, in_i.cand_dim_y), in_i.cand_dim_z);
    cs_d[1] = umax(umin(in_i.cand_dim_x, in_i.cand_dim_y),
                   umin(umax(in_i.cand_dim_x, in_i.cand_dim_y), in_i.cand_dim_z));
    cs_d[2] = umin(umin(in_i.cand_dim_x, in_i.cand_dim_y), in_i.cand_dim_z);
    rs_d[0] = umax(umax(in_i.ref_dim_x, in_i.ref_dim_y), in_i.ref_dim_z);
    rs_d[1] = umax(umin(in_i.ref_dim_x, in_i.ref_dim_y),
                   umin(umax(in_i.ref_dim_x, in_i.ref_dim_y), in_i.ref_dim_z));
    rs_d[2] = umin(umin(in_i.ref_dim_x, in_i.ref_dim_y), in_i.ref_dim_z);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cs_q[i] <= umax(cs_d[i], floor_v);
        rs_q[i] <= umax(rs_d[i], floor_v);
      end
      d_q[0] <= pos_dist(in_i.cand_pos_x, in_i.ref_pos_x);
      d_q[1] <= pos_dist(in_i.cand_pos_y, in_i.ref_pos_y);
      d_q[2] <= pos_dist(in_i.cand_pos_z, in_i.ref_pos_z);
    end
  end

  // ---------------------------------------------------------------- aspect path
  logic [DIM_W-1:0]   rat_num [4];
  logic [DIM_W-1:0]   rat_den [4];
  logic [RAT_W-1:0]   rat     [4];

  assign rat_num[0] = cs_q[2];
  assign rat_num[1] = cs_q[1];
  assign rat_num[2] = rs_q[2];
  assign rat_num[3] = rs_q[1];
  assign rat_den[0] = cs_q[0];
  assign rat_den[1] = cs_q[0];
  assign rat_den[2] = rs_q[0];
  assign rat_den[3] = rs_q[0];

  for (genvar r = 0; r < 4; r++) begin : g_ratio
    // (num << F) / max, num never above max so the quotient fits F+1 bits
    bsim_div #(.VW(DIM_W), .QW(RAT_W), .SW(1)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .hi_i   (DIM_W'(rat_num[r] >> 1)),
      .lo_i   ({rat_num[r][0], {F{1'b0}}}),
      .div_i  (rat_den[r]),
      .side_i (1'b0),
      .quo_o  (rat[r]),
      .side_o ()
    );
  end

  logic [RAT_W-1:0]   e1, e2;
  logic [2*RAT_W-1:0] esq1_q, esq2_q;
  logic [ASQ_IW-1:0]  esum_q;
  logic [ASQ_OW-1:0]  asp_root;
  logic [ASP_W-1:0]   asp_val;

  assign e1 = (rat[0] >= rat[2]) ? rat[0] - rat[2] : rat[2] - rat[0];
  assign e2 = (rat[1] >= rat[3]) ? rat[1] - rat[3] : rat[3] - rat[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      esq1_q <= (2*RAT_W)'(e1) * (2*RAT_W)'(e1);
      esq2_q <= (2*RAT_W)'(e2) * (2*RAT_W)'(e2);
      esum_q <= ASQ_IW'(esq1_q) + ASQ_IW'(esq2_q);
    end
  end

  bsim_sqrt #(.IW(ASQ_IW), .SW(1)) u_asp_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (esum_q),
    .side_i (1'b0),
    .root_o (asp_root),
    .side_o ()
  );

  assign asp_val = ((asp_root >> ASP_W) != '0) ? ASP_MAX : ASP_W'(asp_root);

  // ---------------------------------------------------------------- volume path
  logic [VP_W-1:0]    pc_q, pr_q;
  logic [DIM_W-1:0]   cz_q, rz_q;
  logic [VP_W-1:0]    pcl_q, pch_q, prl_q, prh_q;
  logic [VOL_P_W-1:0] vc_q, vr_q;
  logic [VOL_P_W-1:0] vnum_q, vden_q;
  logic               vsat_q;
  logic [VD_W-1:0]    vdiv;
  logic [VOL_W-1:0]   vol_quo;
  logic               vol_sat;
  logic [VOL_W-1:0]   vol_val;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_q   <= VP_W'(cs_q[0]) * VP_W'(cs_q[1]);
      pr_q   <= VP_W'(rs_q[0]) * VP_W'(rs_q[1]);
      cz_q   <= cs_q[2];
      rz_q   <= rs_q[2];
      // 46 x 23 product split into two 23 x 23 halves
      pcl_q  <= VP_W'(pc_q[DIM_W-1:0]) * VP_W'(cz_q);
      pch_q  <= VP_W'(pc_q[VP_W-1:DIM_W]) * VP_W'(cz_q);
      prl_q  <= VP_W'(pr_q[DIM_W-1:0]) * VP_W'(rz_q);
      prh_q  <= VP_W'(pr_q[VP_W-1:DIM_W]) * VP_W'(rz_q);
      vc_q   <= {pch_q, {DIM_W{1'b0}}} + VOL_P_W'(pcl_q);
      vr_q   <= {prh_q, {DIM_W{1'b0}}} + VOL_P_W'(prl_q);
      vnum_q <= (vc_q >= vr_q) ? vc_q - vr_q : vr_q - vc_q;
      vden_q <= vr_q;
      // quotient would need more than VOL_W bits
      vsat_q <= (vc_q >= vr_q ? (VOL_P_W+VSH_W)'(vc_q - vr_q) : (VOL_P_W+VSH_W)'(vr_q - vc_q))
                >= {vr_q, {VSH_W{1'b0}}};
    end
  end

  assign vdiv = {vnum_q, {F{1'b0}}};

  bsim_div #(.VW(VOL_P_W), .QW(VOL_W), .SW(1)) u_vol_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .hi_i   (VOL_P_W'(vdiv >> VOL_W)),
    .lo_i   (vdiv[VOL_W-1:0]),
    .div_i  (vden_q),
    .side_i (vsat_q),
    .quo_o  (vol_quo),
    .side_o (vol_sat)
  );

  assign vol_val = vol_sat ? VOL_MAX : vol_quo;

  // ---------------------------------------------------------------- distance path
  logic [2*C-1:0]    dsq_q [3];
  logic              far1_q, far2_q;
  logic [DSQ_IW-1:0] dsum_q;
  logic [DSQ_OW-1:0] dist_root;
  logic              dist_far;
  logic [DIST_W-1:0] dist_val;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dsq_q[i] <= (2*C)'(d_q[i]) * (2*C)'(d_q[i]);
      end
      far1_q <= ((d_q[0] >> DIST_W) != '0) || ((d_q[1] >> DIST_W) != '0) ||
                ((d_q[2] >> DIST_W) != '0);
      dsum_q <= DSQ_IW'(dsq_q[0]) + DSQ_IW'(dsq_q[1]) + DSQ_IW'(dsq_q[2]);
      far2_q <= far1_q;
    end
  end

  bsim_sqrt #(.IW(DSQ_IW), .SW(1)) u_dist_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (dsum_q),
    .side_i (far2_q),
    .root_o (dist_root),
    .side_o (dist_far)
  );

  assign dist_val = (dist_far || ((dist_root >> DIST_W) != '0)) ? DIST_MAX
                                                                : DIST_W'(dist_root);

  // ---------------------------------------------------------------- alignment
  logic [ASP_W-1:0]  asp_al;
  logic [VOL_W-1:0]  vol_al;
  logic [DIST_W-1:0] dist_al;

  if (DA_ASP == 0) begin : g_asp_nodl
    assign asp_al = asp_val;
  end else begin : g_asp_dl
    logic [ASP_W-1:0] dl_q [DA_ASP];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[0] <= asp_val;
        for (int k = 1; k < DA_ASP; k++) dl_q[k] <= dl_q[k-1];
      end
    end
    assign asp_al = dl_q[DA_ASP-1];
  end

  if (DA_VOL == 0) begin : g_vol_nodl
    assign vol_al = vol_val;
  end else begin : g_vol_dl
    logic [VOL_W-1:0] dl_q [DA_VOL];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[0] <= vol_val;
        for (int k = 1; k < DA_VOL; k++) dl_q[k] <= dl_q[k-1];
      end
    end
    assign vol_al = dl_q[DA_VOL-1];
  end

  if (DA_DST == 0) begin : g_dst_nodl
    assign dist_al = dist_val;
  end else begin : g_dst_dl
    logic [DIST_W-1:0] dl_q [DA_DST];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[0] <= dist_val;
        for (int k = 1; k < DA_DST; k++) dl_q[k] <= dl_q[k-1];
      end
    end
    assign dist_al = dl_q[DA_DST-1];
  end

  // ---------------------------------------------------------------- weighted means
  logic [MEAN_W-1:0] nums_q, numo_q;
  logic [SB_W-1:0]   sb_q, sb_out;
  logic [DEN_W-1:0]  den_s, den_o;
  logic [MEAN_W-1:0] q_s, q_o;

  // the user must change weights only while idle (the block does not enforce it), so the live values serve every stage
  assign den_s = DEN_W'(w_asp_q) + DEN_W'(w_vol_q);
  assign den_o = den_s + DEN_W'(w_dst_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nums_q <= MEAN_W'(w_asp_q) * MEAN_W'(asp_al) + MEAN_W'(w_vol_q) * MEAN_W'(vol_al);
      numo_q <= MEAN_W'(w_asp_q) * MEAN_W'(asp_al) + MEAN_W'(w_vol_q) * MEAN_W'(vol_al) +
                MEAN_W'(w_dst_q) * MEAN_W'(dist_al);
      sb_q   <= {asp_al, vol_al, dist_al};
    end
  end

  bsim_div #(.VW(DEN_W), .QW(MEAN_W), .SW(1)) u_stat_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .hi_i   ('0),
    .lo_i   (nums_q),
    .div_i  (den_s),
    .side_i (1'b0),
    .quo_o  (q_s),
    .side_o ()
  );

  bsim_div #(.VW(DEN_W), .QW(MEAN_W), .SW(SB_W)) u_over_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .hi_i   ('0),
    .lo_i   (numo_q),
    .div_i  (den_o),
    .side_i (sb_q),
    .quo_o  (q_o),
    .side_o (sb_out)
  );

  // ---------------------------------------------------------------- output register
  logic [ASP_W-1:0]  asp_out_q;
  logic [VOL_W-1:0]  vol_out_q;
  logic [DIST_W-1:0] dist_out_q;
  logic [DIST_W-1:0] over_out_q;
  logic [VOL_W-1:0]  stat_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      asp_out_q  <= sb_out[SB_W-1 -: ASP_W];
      vol_out_q  <= sb_out[DIST_W +: VOL_W];
      dist_out_q <= sb_out[DIST_W-1:0];
      if (den_s == '0) begin
        stat_out_q <= '0;
      end else if ((q_s >> VOL_W) != '0) begin
        stat_out_q <= VOL_MAX;
      end else begin
        stat_out_q <= VOL_W'(q_s);
      end
      if (den_o == '0) begin
        over_out_q <= '0;
      end else if ((q_o >> DIST_W) != '0) begin
        over_out_q <= DIST_MAX;
      end else begin
        over_out_q <= DIST_W'(q_o);
      end
    end
  end

  assign out_o.valid          = vld_q[LAT_TOT-1];
  assign out_o.aspect_error   = asp_out_q;
  assign out_o.volume_error   = vol_out_q;
  assign out_o.distance_error = dist_out_q;
  assign out_o.overall_error  = over_out_q;
  assign out_o.static_error   = stat_out_q;

  // ---------------------------------------------------------------- assertions
  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid pipeline moved during a stall");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(in_i.valid))
    else $error("accepted request did not enter the pipeline");

  a_static_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT_TOT-1] && asp_out_q == '0 && vol_out_q == '0) |-> stat_out_q == '0)
    else $error("static error nonzero with zero aspect and volume errors");

  a_overall_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT_TOT-1] && asp_out_q == '0 && vol_out_q == '0 && dist_out_q == '0)
    |-> over_out_q == '0)
    else $error("overall error nonzero with all component errors zero");

endmodule
